// File: hdl/rotor_saturate_and_map_unit_assert.svh
// Assertion macros for the rotor saturate and map unit.
// Used by the checker; expects clk and arst_n in scope.
`ifndef ROTOR_SATURATE_AND_MAP_UNIT_ASSERT_SVH
`define ROTOR_SATURATE_AND_MAP_UNIT_ASSERT_SVH

// clocked assertion, off while reset is applied
`define RSMU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form
`define RSMU_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`RSMU_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: hdl/rsmu_pkg.sv
// Package for the rotor saturate and map unit: widths, reset values,
// register indexes and pipeline latency. No dependencies.
`default_nettype none
package rsmu_pkg;
	localparam int SPEED_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF  = 16;
	localparam int LIMIT_WIDTH     = 23;
	localparam int GAIN_WIDTH      = 32;
	localparam int MIX_WIDTH       = 64;
	localparam int MIX_SLOT        = 16;
	localparam int OUT_WIDTH       = 32;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int THRUST_SHIFT    = 22;
	localparam int PIPE_LATENCY    = LIMIT_WIDTH + 7;

	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 23'd1024000;
	localparam logic [GAIN_WIDTH-1:0]  GAIN_RESET  = 32'd16777216;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_SPEED_LIMIT = 3'd0,
		REG_THRUST_GAIN = 3'd1,
		REG_MIX_X       = 3'd2,
		REG_MIX_Y       = 3'd3,
		REG_MIX_Z       = 3'd4
	} cfg_reg_t;
endpackage
`default_nettype wire

// File: hdl/rotor_saturate_and_map_unit.sv
// Top level of the rotor saturate and map unit: torque-priority limiting,
// pipelined divider, torque and thrust mapping. Depends on rsmu_pkg.
//
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------
// request   | start / busy       | common_speed, diff_speed_a..d
// result    | done (one cycle)   | applied_*, torque_x/y/z, thrust
// config    | wr_en              | wr_index, wr_data
//
// One request per cycle; busy stays low. Each result passes the one-bit-per-
// stage restoring divider (23 stages) plus seven stages of compare,
// multiply, sum and round. Reset clears valid bits and mix registers and
// loads the limit and gain reset values.
// The result side cannot stall, so the pipeline always advances.
`default_nettype none
module rotor_saturate_and_map_unit #(
	parameter int SPEED_WIDTH = rsmu_pkg::SPEED_WIDTH_DEF,
	parameter int COEF_WIDTH  = rsmu_pkg::COEF_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [rsmu_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [rsmu_pkg::MIX_WIDTH-1:0] wr_data,
	input  logic start,
	output logic busy,
	input  logic signed [SPEED_WIDTH-1:0] common_speed,
	input  logic signed [SPEED_WIDTH-1:0] diff_speed_a,
	input  logic signed [SPEED_WIDTH-1:0] diff_speed_b,
	input  logic signed [SPEED_WIDTH-1:0] diff_speed_c,
	input  logic signed [SPEED_WIDTH-1:0] diff_speed_d,
	output logic done,
	output logic signed [SPEED_WIDTH-1:0] applied_common,
	output logic signed [SPEED_WIDTH-1:0] applied_diff_a,
	output logic signed [SPEED_WIDTH-1:0] applied_diff_b,
	output logic signed [SPEED_WIDTH-1:0] applied_diff_c,
	output logic signed [SPEED_WIDTH-1:0] applied_diff_d,
	output logic signed [rsmu_pkg::OUT_WIDTH-1:0] torque_x,
	output logic signed [rsmu_pkg::OUT_WIDTH-1:0] torque_y,
	output logic signed [rsmu_pkg::OUT_WIDTH-1:0] torque_z,
	output logic signed [rsmu_pkg::OUT_WIDTH-1:0] thrust
);
	import rsmu_pkg::*;

	localparam int W  = SPEED_WIDTH;
	localparam int C  = COEF_WIDTH;
	localparam int LW = LIMIT_WIDTH;
	localparam int MW = (W + 1 > LW) ? W + 1 : LW;
	localparam int PW = W + LW;
	localparam int AW = C + W + 2;
	localparam int EW = W + GAIN_WIDTH + 2;
	localparam int OW = OUT_WIDTH;

	localparam logic signed [MW:0] SPD_MAX = (MW+1)'({(W-1){1'b1}});
	localparam logic signed [MW:0] SPD_MIN = ~SPD_MAX;
	localparam logic [EW-1:0] OUT_MAX = {{(EW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] OUT_POS = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] OUT_NEG = {1'b1, {(OW-1){1'b0}}};

	function automatic logic signed [W-1:0] sat_w(input logic signed [MW:0] v);
		if (v > SPD_MAX) begin
			sat_w = SPD_MAX[W-1:0];
		end else if (v < SPD_MIN) begin
			sat_w = SPD_MIN[W-1:0];
		end else begin
			sat_w = v[W-1:0];
		end
	endfunction

	function automatic logic [OW-1:0] round_sat(input logic neg, input logic [EW-1:0] m,
			input int sh);
		logic [EW-1:0] r;
		r = (m + (EW'(1) << (sh - 1))) >> sh;
		if (r > OUT_MAX) begin
			round_sat = neg ? OUT_NEG : OUT_POS;
		end else begin
			round_sat = neg ? OW'(-r) : OW'(r);
		end
	endfunction

	// configuration
	logic [LW-1:0]         limit_q;
	logic [GAIN_WIDTH-1:0] gain_q;
	logic [MIX_WIDTH-1:0]  mix_q [3];
	logic signed [C-1:0]   coef [3][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			gain_q   <= GAIN_RESET;
			mix_q[0] <= '0;
			mix_q[1] <= '0;
			mix_q[2] <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_SPEED_LIMIT: limit_q <= wr_data[LW-1:0];
				REG_THRUST_GAIN: gain_q <= wr_data[GAIN_WIDTH-1:0];
				REG_MIX_X: mix_q[0] <= wr_data;
				REG_MIX_Y: mix_q[1] <= wr_data;
				REG_MIX_Z: mix_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 4; i++) begin
				coef[r][i] = mix_q[r][MIX_SLOT*i +: C];
			end
		end
	end

	assign busy = 1'b0;

	// stage 1: capture request
	logic v_s1;
	logic signed [W-1:0] g0_s1;
	logic signed [W-1:0] d_s1 [4];

	always_ff @(posedge clk) begin
		g0_s1   <= common_speed;
		d_s1[0] <= diff_speed_a;
		d_s1[1] <= diff_speed_b;
		d_s1[2] <= diff_speed_c;
		d_s1[3] <= diff_speed_d;
	end

	// stage 2: sums, magnitudes, extremes
	logic v_s2;
	logic signed [W-1:0] g0_s2, dmax_s2, dmin_s2;
	logic signed [W-1:0] d_s2 [4];
	logic [W-1:0] dm_s2 [4];
	logic [W:0]   sm_s2 [4];
	logic signed [W:0] sum_c [4];
	logic signed [W-1:0] mx01, mx23, mn01, mn23;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_c[i] = (W+1)'(d_s1[i]) + (W+1)'(g0_s1);
		end
		mx01 = (d_s1[0] > d_s1[1]) ? d_s1[0] : d_s1[1];
		mx23 = (d_s1[2] > d_s1[3]) ? d_s1[2] : d_s1[3];
		mn01 = (d_s1[0] < d_s1[1]) ? d_s1[0] : d_s1[1];
		mn23 = (d_s1[2] < d_s1[3]) ? d_s1[2] : d_s1[3];
	end

	always_ff @(posedge clk) begin
		g0_s2   <= g0_s1;
		dmax_s2 <= (mx01 > mx23) ? mx01 : mx23;
		dmin_s2 <= (mn01 < mn23) ? mn01 : mn23;
		for (int i = 0; i < 4; i++) begin
			d_s2[i]  <= d_s1[i];
			dm_s2[i] <= d_s1[i][W-1] ? W'(-d_s1[i]) : W'(d_s1[i]);
			sm_s2[i] <= sum_c[i][W] ? (W+1)'(-sum_c[i]) : (W+1)'(sum_c[i]);
		end
	end

	// stage 3: mode decision, recomputed common, dividends
	logic over_c, lt_c;
	logic [W-1:0] mdmax_c, mdmin_c, dabs_c;
	logic signed [MW:0] lim_e, rc_c;
	logic signed [W-1:0] g0_c;
	logic [PW-1:0] prod_c [4];

	always_comb begin
		over_c = 1'b0;
		for (int i = 0; i < 4; i++) begin
			over_c = over_c | (MW'(sm_s2[i]) > MW'(limit_q));
			prod_c[i] = PW'(dm_s2[i]) * PW'(limit_q);
		end
		mdmax_c = dmax_s2[W-1] ? W'(-dmax_s2) : W'(dmax_s2);
		mdmin_c = dmin_s2[W-1] ? W'(-dmin_s2) : W'(dmin_s2);
		dabs_c  = (mdmax_c > mdmin_c) ? mdmax_c : mdmin_c;
		lt_c    = MW'(dabs_c) < MW'(limit_q);
		lim_e   = $signed((MW+1)'(limit_q));
		rc_c    = (g0_s2 > 0) ? (lim_e - (MW+1)'(dmax_s2)) : (-lim_e - (MW+1)'(dmin_s2));
		if (!over_c) begin
			g0_c = g0_s2;
		end else if (lt_c) begin
			g0_c = sat_w(rc_c);
		end else begin
			g0_c = '0;
		end
	end

	// divider stages 0..LW, one quotient bit per stage in stages 1..LW
	logic              dv_sd    [LW+1];
	logic              scale_sd [LW+1];
	logic [W-1:0]      dabs_sd  [LW+1];
	logic signed [W-1:0] g0_sd  [LW+1];
	logic signed [W-1:0] d_sd   [LW+1][4];
	logic [PW-1:0]     prod_sd  [LW+1][4];
	logic [W-1:0]      rem_sd   [LW+1][4];
	logic [LW-1:0]     quo_sd   [LW+1][4];

	always_ff @(posedge clk) begin
		scale_sd[0] <= over_c & ~lt_c;
		dabs_sd[0]  <= dabs_c;
		g0_sd[0]    <= g0_c;
		for (int i = 0; i < 4; i++) begin
			d_sd[0][i]    <= d_s2[i];
			prod_sd[0][i] <= prod_c[i];
			rem_sd[0][i]  <= prod_c[i][PW-1:LW];
			quo_sd[0][i]  <= '0;
		end
	end

	for (genvar j = 1; j <= LW; j++) begin : g_div
		logic [W:0] trial [4];
		logic       ge    [4];

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				trial[i] = {rem_sd[j-1][i], prod_sd[j-1][i][LW-j]};
				ge[i]    = trial[i] >= {1'b0, dabs_sd[j-1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_sd[j] <= 1'b0;
			end else begin
				dv_sd[j] <= dv_sd[j-1];
			end
		end

		always_ff @(posedge clk) begin
			scale_sd[j] <= scale_sd[j-1];
			dabs_sd[j]  <= dabs_sd[j-1];
			g0_sd[j]    <= g0_sd[j-1];
			for (int i = 0; i < 4; i++) begin
				d_sd[j][i]    <= d_sd[j-1][i];
				prod_sd[j][i] <= prod_sd[j-1][i];
				rem_sd[j][i]  <= ge[i] ? W'(trial[i] - {1'b0, dabs_sd[j-1]}) : W'(trial[i]);
				quo_sd[j][i]  <= {quo_sd[j-1][i][LW-2:0], ge[i]};
			end
		end
	end

	// stage 5: applied differentials
	logic v_s5;
	logic signed [W-1:0] g0_s5;
	logic signed [W-1:0] d_s5 [4];
	logic signed [MW:0] qs_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qs_c[i] = d_sd[LW][i][W-1] ? -$signed((MW+1)'(quo_sd[LW][i]))
				: $signed((MW+1)'(quo_sd[LW][i]));
		end
	end

	always_ff @(posedge clk) begin
		g0_s5 <= g0_sd[LW];
		for (int i = 0; i < 4; i++) begin
			if (!scale_sd[LW]) begin
				d_s5[i] <= d_sd[LW][i];
			end else if (dabs_sd[LW] == '0) begin
				d_s5[i] <= '0;
			end else begin
				d_s5[i] <= sat_w(qs_c[i]);
			end
		end
	end

	// stage 6: products
	logic v_s6, neg_s6;
	logic signed [W-1:0] g0_s6;
	logic signed [W-1:0] d_s6 [4];
	logic signed [C+W-1:0] p_s6 [3][4];
	logic [W+GAIN_WIDTH-1:0] tm_s6;
	logic [W-1:0] gabs_c;

	assign gabs_c = g0_s5[W-1] ? W'(-g0_s5) : W'(g0_s5);

	always_ff @(posedge clk) begin
		g0_s6  <= g0_s5;
		neg_s6 <= g0_s5[W-1];
		tm_s6  <= (W+GAIN_WIDTH)'(gabs_c) * (W+GAIN_WIDTH)'(gain_q);
		for (int i = 0; i < 4; i++) begin
			d_s6[i] <= d_s5[i];
			for (int r = 0; r < 3; r++) begin
				p_s6[r][i] <= coef[r][i] * d_s5[i];
			end
		end
	end

	// stage 7: row sums
	logic v_s7, neg_s7;
	logic signed [W-1:0] g0_s7;
	logic signed [W-1:0] d_s7 [4];
	logic signed [AW-1:0] acc_s7 [3];
	logic [W+GAIN_WIDTH-1:0] tm_s7;

	always_ff @(posedge clk) begin
		g0_s7  <= g0_s6;
		neg_s7 <= neg_s6;
		tm_s7  <= tm_s6;
		for (int i = 0; i < 4; i++) begin
			d_s7[i] <= d_s6[i];
		end
		for (int r = 0; r < 3; r++) begin
			acc_s7[r] <= AW'(p_s6[r][0]) + AW'(p_s6[r][1]) + AW'(p_s6[r][2]) + AW'(p_s6[r][3]);
		end
	end

	// stage 8: round, saturate, drive results
	logic done_q;
	logic signed [W-1:0]  common_q;
	logic signed [W-1:0]  diff_q [4];
	logic signed [OW-1:0] torque_q [3];
	logic signed [OW-1:0] thrust_q;
	logic [AW-1:0] accm_c [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			accm_c[r] = acc_s7[r][AW-1] ? AW'(-acc_s7[r]) : AW'(acc_s7[r]);
		end
	end

	always_ff @(posedge clk) begin
		common_q <= g0_s7;
		for (int i = 0; i < 4; i++) begin
			diff_q[i] <= d_s7[i];
		end
		for (int r = 0; r < 3; r++) begin
			torque_q[r] <= round_sat(acc_s7[r][AW-1], EW'(accm_c[r]), C - 4);
		end
		thrust_q <= round_sat(neg_s7, EW'(tm_s7), THRUST_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			dv_sd[0] <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1     <= start & ~busy;
			v_s2     <= v_s1;
			dv_sd[0] <= v_s2;
			v_s5     <= dv_sd[LW];
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			done_q   <= v_s7;
		end
	end

	assign done           = done_q;
	assign applied_common = common_q;
	assign applied_diff_a = diff_q[0];
	assign applied_diff_b = diff_q[1];
	assign applied_diff_c = diff_q[2];
	assign applied_diff_d = diff_q[3];
	assign torque_x       = torque_q[0];
	assign torque_y       = torque_q[1];
	assign torque_z       = torque_q[2];
	assign thrust         = thrust_q;
endmodule
`default_nettype wire

// File: hdl/rsmu_checker.sv
// Port-level checker for the rotor saturate and map unit, with its bind.
// Depends on rsmu_pkg and rotor_saturate_and_map_unit_assert.svh.
`default_nettype none
`include "rotor_saturate_and_map_unit_assert.svh"
module rsmu_checker #(
	parameter int SPEED_WIDTH = rsmu_pkg::SPEED_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [SPEED_WIDTH-1:0] common_speed,
	input logic signed [SPEED_WIDTH-1:0] diff_speed_a,
	input logic signed [SPEED_WIDTH-1:0] diff_speed_b,
	input logic signed [SPEED_WIDTH-1:0] diff_speed_c,
	input logic signed [SPEED_WIDTH-1:0] diff_speed_d,
	input logic signed [SPEED_WIDTH-1:0] applied_common,
	input logic signed [rsmu_pkg::OUT_WIDTH-1:0] thrust
);
	import rsmu_pkg::*;

	logic req, zero_req;

	assign req      = start & ~busy;
	assign zero_req = req && common_speed == '0 && diff_speed_a == '0 &&
		diff_speed_b == '0 && diff_speed_c == '0 && diff_speed_d == '0;

	`RSMU_ASSERT_IMPLY(a_result_follows, req, ##PIPE_LATENCY done, "request produced no result")
	`RSMU_ASSERT_IMPLY(a_no_extra, done, $past(req, PIPE_LATENCY), "result without request")
	`RSMU_ASSERT_IMPLY(a_zero_map, zero_req, ##PIPE_LATENCY (applied_common == '0 && thrust == '0), "zero request gave nonzero common or thrust")
endmodule

bind rotor_saturate_and_map_unit rsmu_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_rsmu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.common_speed(common_speed),
	.diff_speed_a(diff_speed_a),
	.diff_speed_b(diff_speed_b),
	.diff_speed_c(diff_speed_c),
	.diff_speed_d(diff_speed_d),
	.applied_common(applied_common),
	.thrust(thrust)
);
`default_nettype wire
